FILE: rtl/b32sc_pkg.sv
// Shared types and constants for the base32 stream codec.
// No dependencies; compile first.
`default_nettype none
package b32sc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_LIMIT = 3'd5;

  localparam int unsigned ACC_W      = 12;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned SYM_W      = 5;
  localparam int unsigned NUM_SYMS   = 32;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned MAX_BEATS  = 3;   // result beats one item can cause

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // one queued result beat; symbols are mapped to characters at the output
  typedef struct packed {
    logic       is_sym;
    logic [7:0] val;
    logic       last;
    logic       stopped;
  } res_beat_t;

endpackage
`default_nettype wire

FILE: rtl/b32sc_if.sv
// Valid/ready stream interfaces for the codec input and result channels.
// Depends on nothing; compile after b32sc_pkg.
`default_nettype none
interface b32sc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       message_end;

  modport source (output valid, output data_in, output message_end, input ready);
  modport sink   (input valid, input data_in, input message_end, output ready);
endinterface

interface b32sc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       run_last;
  logic       stopped;

  modport source (output valid, output data_out, output run_last, output stopped,
                  input ready);
  modport sink   (input valid, input data_out, input run_last, input stopped,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/base32_stream_codec.sv
// Base32 stream codec top level: bit accumulator, 32-entry alphabet, result queue.
// Depends on b32sc_pkg and the stream interfaces in b32sc_if.sv.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    data_in[7:0], message_end
//   out_o    out  valid/ready    data_out[7:0], run_last, stopped
//   cfg      in   cfg_we_i       cfg_idx_i[2:0], cfg_data_i[63:0]
//
// Each accepted beat is processed in the cycle it is taken; its 0..3 result
// beats land in a 4-deep result queue; its head drives out_o, data via the alphabet.
// in_i.ready is high while at most one result beat is queued, so decoding runs
// one item per cycle while out_o takes beats; encoding, where a byte can yield
// two symbols and a flush one more, is set by the single output beat per cycle.
// Reset clears the message state, the queue and the configuration (decode
// limit 65535). Output stalls just fill the queue; input then waits.
`default_nettype none
module base32_stream_codec
  import b32sc_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [CFG_DATA_W-1:0]  cfg_data_i,
  b32sc_in_if.sink              in_i,
  b32sc_out_if.source           out_o
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // ---------------------------------------------------------------- config
  logic                        dir_q;
  logic [NUM_SYMS-1:0][7:0]    alph_q;
  logic [LIMIT_W-1:0]          limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= DIR_ENCODE;
      alph_q  <= '0;
      limit_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIRECTION: dir_q <= cfg_data_i[0];
        CFG_ALPHABET0, CFG_ALPHABET1, CFG_ALPHABET2, CFG_ALPHABET3: begin
          for (int j = 0; j < 8; j++) begin
            alph_q[{2'(cfg_idx_i - CFG_ALPHABET0), 3'(j)}] <= cfg_data_i[8*j +: 8];
          end
        end
        CFG_DEC_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;  // writes past the register list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   bcnt_q, bcnt_d;
  logic               halt_q, halt_d;
  logic [LIMIT_W-1:0] bytes_q, bytes_d;

  logic [QPTR_W-1:0]  wr_q, rd_q;
  logic [QCNT_W-1:0]  qcnt_q;
  res_beat_t          queue_q [QDEPTH];

  logic in_acc, out_acc;
  assign in_i.ready = (qcnt_q <= QCNT_W'(QDEPTH - MAX_BEATS));
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_acc    = out_o.valid && out_o.ready;

  function automatic logic [ACC_W-1:0] low_mask(input logic [CNT_W-1:0] n);
    logic [ACC_W:0] m;
    m = ({{ACC_W{1'b0}}, 1'b1} << n) - 1'b1;
    return m[ACC_W-1:0];
  endfunction

  // ------------------------------------------------------- alphabet search
  logic [NUM_SYMS-1:0] hit_vec;
  logic                hit;
  logic [SYM_W-1:0]    hit_sym;

  always_comb begin
    for (int i = 0; i < NUM_SYMS; i++) begin
      hit_vec[i] = (alph_q[i] == in_i.data_in);
    end
    hit     = |hit_vec;
    hit_sym = '0;
    // lowest matching symbol wins on duplicate characters
    for (int i = NUM_SYMS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_sym = SYM_W'(i);
    end
  end

  // ------------------------------------------------------- per-item datapath
  logic [CNT_W-1:0]  e_cnt, e_cnt0, e_cnt1, e_cnt2;
  logic [ACC_W-1:0]  e_acc;
  logic [CNT_W-1:0]  d_cnt, d_cnt0;
  logic [ACC_W-1:0]  d_acc;
  res_beat_t         beat [MAX_BEATS];
  logic [1:0]        n_beats;

  always_comb begin
    acc_d   = acc_q;
    bcnt_d  = bcnt_q;
    halt_d  = halt_q;
    bytes_d = bytes_q;
    n_beats = '0;
    for (int k = 0; k < MAX_BEATS; k++) begin
      beat[k] = '{is_sym: 1'b0, val: 8'h00, last: 1'b0, stopped: halt_q};
    end

    // encode: 8 bits in, one or two 5-bit groups out, flush on message end
    e_cnt  = (bcnt_q > 4'd4) ? 4'd4 : bcnt_q;
    e_acc  = ACC_W'({(acc_q & low_mask(e_cnt)), in_i.data_in});
    e_cnt0 = e_cnt + 4'd8;
    e_cnt1 = e_cnt0 - 4'd5;
    e_cnt2 = (e_cnt1 >= 4'd5) ? (e_cnt1 - 4'd5) : e_cnt1;

    // decode: 5 bits in, at most one byte out
    d_cnt  = (bcnt_q > 4'd7) ? 4'd7 : bcnt_q;
    d_acc  = ACC_W'({(acc_q & low_mask(d_cnt)), hit_sym});
    d_cnt0 = d_cnt + 4'd5;

    if (dir_q == DIR_ENCODE) begin
      beat[0].is_sym = 1'b1;
      beat[0].val    = {3'b000, SYM_W'(e_acc >> (e_cnt0 - 4'd5))};
      n_beats        = 2'd1;
      if (e_cnt1 >= 4'd5) begin
        beat[1].is_sym = 1'b1;
        beat[1].val    = {3'b000, SYM_W'(e_acc >> (e_cnt1 - 4'd5))};
        n_beats        = 2'd2;
      end
      if (in_i.message_end && (e_cnt2 != '0)) begin
        // leftover bits move to the top of the group, zero-filled below
        beat[n_beats].is_sym = 1'b1;
        beat[n_beats].val    = {3'b000, SYM_W'(e_acc << (4'd5 - e_cnt2))};
        n_beats              = n_beats + 2'd1;
      end
      acc_d  = e_acc & low_mask(e_cnt2);
      bcnt_d = e_cnt2;
    end else if (!halt_q) begin
      if (!hit) begin
        halt_d = 1'b1;
      end else begin
        acc_d  = d_acc;
        bcnt_d = d_cnt0;
        if (d_cnt0 >= 4'd8) begin
          bcnt_d = d_cnt0 - 4'd8;
          acc_d  = d_acc & low_mask(d_cnt0 - 4'd8);
          if (bytes_q < limit_q) begin
            beat[0].val = 8'(d_acc >> (d_cnt0 - 4'd8));
            n_beats     = 2'd1;
            bytes_d     = bytes_q + 1'b1;
          end
        end
      end
    end

    for (int k = 0; k < MAX_BEATS; k++) begin
      beat[k].last = (2'(k) == n_beats - 2'd1);
    end

    if (in_i.message_end) begin
      acc_d   = '0;
      bcnt_d  = '0;
      halt_d  = 1'b0;
      bytes_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      bcnt_q  <= '0;
      halt_q  <= 1'b0;
      bytes_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == CFG_DIRECTION)) begin
      // a mode change starts a fresh message
      acc_q   <= '0;
      bcnt_q  <= '0;
      halt_q  <= 1'b0;
      bytes_q <= '0;
    end else if (in_acc) begin
      acc_q   <= acc_d;
      bcnt_q  <= bcnt_d;
      halt_q  <= halt_d;
      bytes_q <= bytes_d;
    end
  end

  // ---------------------------------------------------------- result queue
  logic [1:0] n_push;
  assign n_push = in_acc ? n_beats : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      qcnt_q <= '0;
    end else begin
      wr_q   <= wr_q + QPTR_W'(n_push);
      rd_q   <= rd_q + QPTR_W'(out_acc);
      qcnt_q <= qcnt_q + QCNT_W'(n_push) - QCNT_W'(out_acc);
    end
  end

  // payload entries carry no reset
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_BEATS; k++) begin
      if (2'(k) < n_push) queue_q[wr_q + QPTR_W'(k)] <= beat[k];
    end
  end

  res_beat_t head;
  assign head            = queue_q[rd_q];
  assign out_o.valid     = (qcnt_q != '0);
  assign out_o.data_out  = head.is_sym ? alph_q[head.val[SYM_W-1:0]] : head.val;
  assign out_o.run_last  = head.last;
  assign out_o.stopped   = head.stopped;

  // ------------------------------------------------------------ assertions
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcnt_q <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_bitcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= 4'd7)
    else $error("bit count out of range");

  a_msg_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.message_end && !cfg_we_i) |=>
      (bcnt_q == '0 && !halt_q && bytes_q == '0))
    else $error("message end did not clear state");

  a_no_result_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !out_o.stopped)
    else $error("result beat made while halted");

  a_limit_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && dir_q == DIR_DECODE && n_beats != 2'd0) |-> (bytes_q < limit_q))
    else $error("decoded byte past limit");

endmodule
`default_nettype wire
